// ----- design/rgbamip_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbamip_pkg
// Shared types and constants of the RGBA 2x2 box-filter mipmap chain.
// ----------------------------------------------------------------------------
package rgbamip_pkg;

  localparam int MAX_SIDE_LOG2 = 10;
  localparam int MAX_SIDE      = 1 << MAX_SIDE_LOG2;
  localparam int LVL_W         = $clog2(MAX_SIDE_LOG2 + 1);
  localparam int CNT_W         = MAX_SIDE_LOG2;
  localparam int SIDE_W        = MAX_SIDE_LOG2 + 1;
  localparam int ADDR_W        = MAX_SIDE_LOG2;
  localparam int COORD_W       = 9;
  localparam int NUM_CH        = 4;

  // channel 0 is red, then green, blue, alpha
  typedef logic [NUM_CH-1:0][7:0] rgba_t;
  typedef logic [NUM_CH-1:0][8:0] pair_t;

  localparam int PAIR_W = $bits(pair_t);

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } in_pix_t;

  typedef struct packed {
    logic [3:0]         mip_level;
    logic [COORD_W-1:0] pix_x;
    logic [COORD_W-1:0] pix_y;
    logic [7:0]         out_red;
    logic [7:0]         out_green;
    logic [7:0]         out_blue;
    logic [7:0]         out_alpha;
    logic               run_last;
  } mip_pix_t;

endpackage

// ----- design/rgbamip_ram.sv -----
// ----------------------------------------------------------------------------
// rgbamip_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module rgbamip_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/rgba_box_mipmap_chain_unit.sv -----
// ----------------------------------------------------------------------------
// rgba_box_mipmap_chain_unit
// Streams level-0 RGBA8 pixels in raster order and emits every pixel of
// levels 1..side_log2 as soon as its 2x2 source square is complete.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------
//  in      | in_valid / in_stall    | in_data  (rgbamip_pkg::in_pix_t)
//  out     | out_valid / out_stall  | out_data (rgbamip_pkg::mip_pix_t)
//  cfg     | cfg_valid / cfg_ready  | cfg_data (side_log2, 4 bits)
//
// One level step per cycle through the shared pair-sum RAM unless a stalled
// output holds it; a pixel that completes levels steps through them one by
// one, the input waiting on each RAM read.
// The output register takes a result while the next level step runs.
// Reset clears the level counters and sets side_log2 to 10; no RAM clearing.
// A stalled output holds the input once a result also waits in the read stage.
// ----------------------------------------------------------------------------
module rgba_box_mipmap_chain_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rgbamip_pkg::in_pix_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rgbamip_pkg::mip_pix_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [3:0]            cfg_data
);

  // configuration
  logic [rgbamip_pkg::LVL_W-1:0] side_log2;
  logic [rgbamip_pkg::LVL_W-1:0] side_log2_next;
  logic                          cfg_take;

  // per-level state
  logic [rgbamip_pkg::CNT_W-1:0] level_column [rgbamip_pkg::MAX_SIDE_LOG2];
  logic [rgbamip_pkg::CNT_W-1:0] level_row    [rgbamip_pkg::MAX_SIDE_LOG2];
  rgbamip_pkg::rgba_t            left_hold    [rgbamip_pkg::MAX_SIDE_LOG2];

  // read stage: a level step waiting for its pair-sum row
  logic                            rd_valid;
  logic [rgbamip_pkg::LVL_W-1:0]   rd_level;
  logic [rgbamip_pkg::COORD_W-1:0] rd_x;
  logic [rgbamip_pkg::COORD_W-1:0] rd_y;
  rgbamip_pkg::pair_t              rd_pair;
  rgbamip_pkg::pair_t              ram_rdata;

  // output register
  rgbamip_pkg::mip_pix_t out_reg;
  logic                  out_reg_valid;

  // step logic
  rgbamip_pkg::rgba_t               ch_in;
  rgbamip_pkg::rgba_t               avg;
  rgbamip_pkg::rgba_t               step_ch;
  rgbamip_pkg::pair_t               pair;
  logic [rgbamip_pkg::LVL_W-1:0]    next_lvl;
  logic [rgbamip_pkg::LVL_W-1:0]    step_lvl;
  logic [rgbamip_pkg::LVL_W-1:0]    shamt;
  logic [rgbamip_pkg::SIDE_W-1:0]   size;
  logic [rgbamip_pkg::SIDE_W-1:0]   side;
  logic [rgbamip_pkg::CNT_W-1:0]    col_cur;
  logic [rgbamip_pkg::CNT_W-1:0]    row_cur;
  logic [rgbamip_pkg::CNT_W-1:0]    lim;
  rgbamip_pkg::rgba_t               hold_cur;
  logic [rgbamip_pkg::ADDR_W-1:0]   idx;
  logic                             casc_ok;
  logic                             adv;
  logic                             in_take;
  logic                             step_go;
  logic                             mem_we;
  logic                             mem_re;
  rgbamip_pkg::mip_pix_t            res;

  assign cfg_ready = !rd_valid;
  assign cfg_take  = cfg_valid && cfg_ready;

  always_comb begin
    if (cfg_data == 4'd0) begin
      side_log2_next = rgbamip_pkg::LVL_W'(1);
    end else if (cfg_data > 4'(rgbamip_pkg::MAX_SIDE_LOG2)) begin
      side_log2_next = rgbamip_pkg::LVL_W'(rgbamip_pkg::MAX_SIDE_LOG2);
    end else begin
      side_log2_next = rgbamip_pkg::LVL_W'(cfg_data);
    end
  end

  assign ch_in = {in_data.in_alpha, in_data.in_blue, in_data.in_green, in_data.in_red};

  always_comb begin
    for (int k = 0; k < rgbamip_pkg::NUM_CH; k++) begin
      avg[k] = 8'((10'(ram_rdata[k]) + 10'(rd_pair[k])) >> 2);
    end
  end

  // the read stage hands its average to the next level in the same cycle
  assign next_lvl = rd_level + rgbamip_pkg::LVL_W'(1);
  assign casc_ok  = rd_valid && (next_lvl < side_log2);
  assign adv      = !rd_valid || !out_reg_valid || !out_stall;
  assign in_stall = !(adv && !casc_ok);
  assign in_take  = in_valid && !in_stall;
  assign step_go  = (adv && casc_ok) || in_take;
  assign step_lvl = casc_ok ? next_lvl : '0;
  assign step_ch  = casc_ok ? avg : ch_in;

  assign col_cur  = level_column[step_lvl];
  assign row_cur  = level_row[step_lvl];
  assign hold_cur = left_hold[step_lvl];

  assign shamt = side_log2 - step_lvl;
  assign size  = rgbamip_pkg::SIDE_W'(1) << shamt;
  assign side  = rgbamip_pkg::SIDE_W'(1) << side_log2;
  assign lim   = rgbamip_pkg::CNT_W'(size - rgbamip_pkg::SIDE_W'(1));
  assign idx   = rgbamip_pkg::ADDR_W'(side - size) + rgbamip_pkg::ADDR_W'(col_cur >> 1);

  always_comb begin
    for (int k = 0; k < rgbamip_pkg::NUM_CH; k++) begin
      pair[k] = 9'(hold_cur[k]) + 9'(step_ch[k]);
    end
  end

  // right pixel of a pair: even row stores the pair sum, odd row fetches it
  assign mem_we = step_go && col_cur[0] && !row_cur[0];
  assign mem_re = step_go && col_cur[0] && row_cur[0];

  always_comb begin
    res.mip_level = 4'(next_lvl);
    res.pix_x     = rd_x;
    res.pix_y     = rd_y;
    res.out_red   = avg[0];
    res.out_green = avg[1];
    res.out_blue  = avg[2];
    res.out_alpha = avg[3];
    res.run_last  = !(casc_ok && col_cur[0] && row_cur[0]);
  end

  rgbamip_ram #(
    .WIDTH(rgbamip_pkg::PAIR_W),
    .DEPTH(rgbamip_pkg::MAX_SIDE)
  ) u_pair_rows (
    .clk  (clk),
    .we   (mem_we),
    .waddr(idx),
    .wdata(pair),
    .re   (mem_re),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      side_log2     <= rgbamip_pkg::LVL_W'(rgbamip_pkg::MAX_SIDE_LOG2);
      rd_valid      <= 1'b0;
      out_reg_valid <= 1'b0;
      for (int i = 0; i < rgbamip_pkg::MAX_SIDE_LOG2; i++) begin
        level_column[i] <= '0;
        level_row[i]    <= '0;
      end
    end else begin
      if (cfg_take) begin
        side_log2 <= side_log2_next;
        for (int i = 0; i < rgbamip_pkg::MAX_SIDE_LOG2; i++) begin
          level_column[i] <= '0;
          level_row[i]    <= '0;
        end
      end else if (step_go) begin
        if (col_cur == lim) begin
          level_column[step_lvl] <= '0;
          level_row[step_lvl]    <= (row_cur == lim) ? '0 :
                                    row_cur + rgbamip_pkg::CNT_W'(1);
        end else begin
          level_column[step_lvl] <= col_cur + rgbamip_pkg::CNT_W'(1);
        end
      end
      if (adv) begin
        rd_valid <= mem_re;
      end
      if (adv && rd_valid) begin
        out_reg_valid <= 1'b1;
      end else if (!out_stall) begin
        out_reg_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && !col_cur[0]) begin
      left_hold[step_lvl] <= step_ch;
    end
    if (adv && mem_re) begin
      rd_level <= step_lvl;
      rd_x     <= col_cur[rgbamip_pkg::CNT_W-1:1];
      rd_y     <= row_cur[rgbamip_pkg::CNT_W-1:1];
      rd_pair  <= pair;
    end
    if (adv && rd_valid) begin
      out_reg <= res;
    end
  end

  assign out_valid = out_reg_valid;
  assign out_data  = out_reg;

endmodule

// ----- design/rgbamip_chk.sv -----
// ----------------------------------------------------------------------------
// rgbamip_chk
// Port-level checks of the mipmap chain unit, bound to the top level.
// ----------------------------------------------------------------------------
module rgbamip_chk (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_stall,
  input rgbamip_pkg::mip_pix_t out_data
);

  // a held beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.mip_level >= 4'd1
              && out_data.mip_level <= 4'(rgbamip_pkg::MAX_SIDE_LOG2))
    else $error("mip level out of range");

  // a cascade emits its next level in the very next cycle
  a_cascade: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.run_last
      |=> out_valid && out_data.mip_level == 4'($past(out_data.mip_level) + 4'd1))
    else $error("cascade result missing or out of order");

endmodule

bind rgba_box_mipmap_chain_unit rgbamip_chk u_rgbamip_chk (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

// ----- tb/rgba_box_mipmap_chain_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgba_box_mipmap_chain_unit_tb
// Drives level-0 RGBA8 images into the mipmap chain, mirrors the 2x2 box
// filter cascade in a local model and checks every emitted level pixel,
// its coordinates and its last-of-input marker in order of arrival.
// ----------------------------------------------------------------------------
module rgba_box_mipmap_chain_unit_tb;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 2 * rgbamip_pkg::MAX_SIDE_LOG2 + 8;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 150;

  // receiver stall patterns
  localparam int RX_FREE = 0;
  localparam int RX_LIGHT = 1;
  localparam int RX_HEAVY = 2;
  localparam int RX_PERIODIC = 3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  rgbamip_pkg::in_pix_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rgbamip_pkg::mip_pix_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_data = '0;

  // local copy of the filter state
  rgbamip_pkg::pair_t pair_rows [rgbamip_pkg::MAX_SIDE];
  rgbamip_pkg::rgba_t left_hold [rgbamip_pkg::MAX_SIDE_LOG2];
  int unsigned lvl_col [rgbamip_pkg::MAX_SIDE_LOG2];
  int unsigned lvl_row [rgbamip_pkg::MAX_SIDE_LOG2];
  int unsigned side_now;

  rgbamip_pkg::mip_pix_t mip_expect_q[$];
  int err_cnt = 0;
  int cycle_cnt = 0;
  int burst_left = 0;
  int hold_req_cnt = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_mode = RX_FREE;
  int rx_mode_left = 0;

  rgba_box_mipmap_chain_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stall: random patterns, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req_cnt != hold_seen) begin
      hold_seen = hold_req_cnt;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(RX_FREE, RX_PERIODIC);
        rx_mode_left = $urandom_range(10, 80);
      end
      rx_mode_left--;
      case (rx_mode)
        RX_FREE: out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ((cycle_cnt % 5) < 2);
      endcase
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    rgbamip_pkg::mip_pix_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (mip_expect_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, actual level %0d (%0d,%0d)",
                 $time, out_data.mip_level, out_data.pix_x, out_data.pix_y);
      end else begin
        want = mip_expect_q.pop_front();
        check_field("mip_level", want.mip_level, out_data.mip_level);
        check_field("pix_x", want.pix_x, out_data.pix_x);
        check_field("pix_y", want.pix_y, out_data.pix_y);
        check_field("out_red", want.out_red, out_data.out_red);
        check_field("out_green", want.out_green, out_data.out_green);
        check_field("out_blue", want.out_blue, out_data.out_blue);
        check_field("out_alpha", want.out_alpha, out_data.out_alpha);
        check_field("run_last", want.run_last, out_data.run_last);
      end
    end
  end

  // cascade one level-0 pixel through every level it completes
  function automatic void predict_mips(input rgbamip_pkg::in_pix_t p);
    rgbamip_pkg::rgba_t cur;
    rgbamip_pkg::pair_t sum;
    rgbamip_pkg::pair_t upper;
    rgbamip_pkg::mip_pix_t res;
    rgbamip_pkg::mip_pix_t found[$];
    int unsigned side;
    int unsigned size;
    int unsigned x;
    int unsigned y;
    int unsigned idx;
    int lv;
    int k;
    cur[0] = p.in_red;
    cur[1] = p.in_green;
    cur[2] = p.in_blue;
    cur[3] = p.in_alpha;
    side = 1 << side_now;
    for (lv = 0; lv < side_now; lv++) begin
      size = 1 << (side_now - lv);
      x = lvl_col[lv];
      y = lvl_row[lv];
      lvl_col[lv] = x + 1;
      if (lvl_col[lv] >= size) begin
        lvl_col[lv] = 0;
        lvl_row[lv] = (y + 1 >= size) ? 0 : y + 1;
      end
      if (x % 2 == 0) begin
        left_hold[lv] = cur;
        break;
      end
      for (k = 0; k < rgbamip_pkg::NUM_CH; k++)
        sum[k] = 9'(left_hold[lv][k]) + 9'(cur[k]);
      idx = (side - size + (x >> 1)) % rgbamip_pkg::MAX_SIDE;
      if (y % 2 == 0) begin
        pair_rows[idx] = sum;
        break;
      end
      upper = pair_rows[idx];
      for (k = 0; k < rgbamip_pkg::NUM_CH; k++)
        cur[k] = 8'((10'(upper[k]) + 10'(sum[k])) >> 2);
      res.mip_level = 4'(lv + 1);
      res.pix_x = rgbamip_pkg::COORD_W'(x >> 1);
      res.pix_y = rgbamip_pkg::COORD_W'(y >> 1);
      res.out_red = cur[0];
      res.out_green = cur[1];
      res.out_blue = cur[2];
      res.out_alpha = cur[3];
      res.run_last = 1'b0;
      found.push_back(res);
    end
    if (found.size() > 0)
      found[found.size() - 1].run_last = 1'b1;
    foreach (found[i])
      mip_expect_q.push_back(found[i]);
  endfunction

  function automatic rgbamip_pkg::in_pix_t mk_pix(input logic [7:0] r, input logic [7:0] g,
                                                  input logic [7:0] b, input logic [7:0] a);
    rgbamip_pkg::in_pix_t p;
    p.in_red = r;
    p.in_green = g;
    p.in_blue = b;
    p.in_alpha = a;
    return p;
  endfunction

  // mostly uniform channels, now and then a rail value
  function automatic rgbamip_pkg::in_pix_t rand_pix();
    rgbamip_pkg::in_pix_t p;
    p = rgbamip_pkg::in_pix_t'($urandom);
    if ($urandom_range(0, 7) == 0) p.in_red = $urandom_range(0, 1) ? 8'hff : 8'h00;
    if ($urandom_range(0, 7) == 0) p.in_green = $urandom_range(0, 1) ? 8'hff : 8'h00;
    if ($urandom_range(0, 7) == 0) p.in_blue = $urandom_range(0, 1) ? 8'hff : 8'h00;
    if ($urandom_range(0, 7) == 0) p.in_alpha = $urandom_range(0, 1) ? 8'hff : 8'h00;
    return p;
  endfunction

  // offer one pixel, hold it until the beat is taken
  task automatic drive_pixel(input rgbamip_pkg::in_pix_t p);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_mips(p);
  endtask

  task automatic drive_random(input int count);
    repeat (count) drive_pixel(rand_pix());
  endtask

  // wait out every result, then the cycles of a pixel that emits nothing
  task automatic drain_pipe();
    in_valid <= 1'b0;
    burst_left = 0;
    while (mip_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_side(input logic [3:0] v);
    drain_pipe();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    if (v < 1) side_now = 1;
    else if (v > rgbamip_pkg::MAX_SIDE_LOG2) side_now = rgbamip_pkg::MAX_SIDE_LOG2;
    else side_now = v;
    foreach (lvl_col[i]) begin
      lvl_col[i] = 0;
      lvl_row[i] = 0;
    end
  endtask

  // reset side: the largest image completes nothing within its first row
  task automatic test_reset_side();
    drive_random(64);
  endtask

  task automatic test_extremes();
    write_side(4'd1);
    repeat (4) drive_pixel(mk_pix(8'h00, 8'h00, 8'h00, 8'h00));
    repeat (4) drive_pixel(mk_pix(8'hff, 8'hff, 8'hff, 8'hff));
    // truncation: red, green and blue sums just short of a multiple of four, alpha on one
    drive_pixel(mk_pix(8'hff, 8'h00, 8'h01, 8'h80));
    drive_pixel(mk_pix(8'hff, 8'h00, 8'h01, 8'h7f));
    drive_pixel(mk_pix(8'hff, 8'h01, 8'h01, 8'h80));
    drive_pixel(mk_pix(8'hfe, 8'h02, 8'h00, 8'h81));
  endtask

  task automatic test_side_clamp();
    write_side(4'd0);
    drive_random(4);
    write_side(4'd15);
    drive_random(6);
  endtask

  task automatic test_write_mid_image();
    write_side(4'd2);
    drive_random(6);
    write_side(4'd2);
    drive_random(16);
  endtask

  task automatic test_output_hold_off();
    write_side(4'd4);
    @(negedge clk);
    hold_req_cnt++;
    @(posedge clk);
    drive_random(256);
  endtask

  task automatic test_random_images();
    int sent;
    int sel;
    int v;
    int n;
    int full;
    int cnt;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 15);
      if (sel < 5) v = 1;
      else if (sel < 10) v = 2;
      else if (sel < 14) v = 3;
      else if (sel == 14) v = 4;
      else v = $urandom_range(0, 15);
      write_side(4'(v));
      n = side_now;
      full = (n <= 4) ? (1 << (2 * n)) : 0;
      if (full == 0 || $urandom_range(0, 4) == 0) begin
        // broken image, cut short by the next register write
        cnt = $urandom_range(1, (full == 0 || full > 100) ? 100 : full);
      end else begin
        cnt = full * $urandom_range(1, 3);
      end
      if (cnt > RANDOM_ITEMS - sent) cnt = RANDOM_ITEMS - sent;
      drive_random(cnt);
      sent += cnt;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    side_now = rgbamip_pkg::MAX_SIDE_LOG2;
    foreach (lvl_col[i]) begin
      lvl_col[i] = 0;
      lvl_row[i] = 0;
    end
    @(posedge clk);
    test_reset_side();
    test_extremes();
    test_side_clamp();
    test_write_mid_image();
    test_output_hold_off();
    test_random_images();
    drain_pipe();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
